// ===== rtl/core/dpd_pkg.sv =====
// Shared types and framing constants for the debug packet deframer.
package dpd_pkg;

  localparam logic [7:0] ByteInterrupt = 8'h03;
  localparam logic [7:0] ByteOpen      = 8'h24;  // '$'
  localparam logic [7:0] ByteClose     = 8'h23;  // '#'
  localparam logic [7:0] ByteEscape    = 8'h7D;  // '}'
  localparam logic [7:0] EscapeMask    = 8'h20;

  typedef enum logic [2:0] {
    PhIdle = 3'd0,
    PhData = 3'd1,
    PhEsc  = 3'd2,
    PhChk1 = 3'd3,
    PhChk2 = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    EvStart = 3'd0,
    EvByte  = 3'd1,
    EvEnd   = 3'd2,
    EvAbort = 3'd3,
    EvIntr  = 3'd4
  } event_e;

  typedef struct packed {
    event_e     kind;
    logic [7:0] payload;
    logic [7:0] chk_hi;
    logic [7:0] chk_lo;
    logic       ack;
  } result_t;

endpackage

// ===== rtl/core/dpd_in_stage.sv =====
// Input register holding one received byte request.
module dpd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/core/dpd_decoder.sv =====
// Framing state machine: decodes one byte into at most one event.
module dpd_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [7:0]       byte_i,
  input  logic             ack_en_i,
  output logic             has_result_o,
  output dpd_pkg::result_t result_o
);

  dpd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      chk1_q, chk1_d;

  always_comb begin
    phase_d      = phase_q;
    chk1_d       = chk1_q;
    has_result_o = 1'b0;
    result_o     = '{kind: dpd_pkg::EvStart, payload: 8'h00, chk_hi: 8'h00,
                     chk_lo: 8'h00, ack: 1'b0};
    unique case (phase_q)
      dpd_pkg::PhData: begin
        if (byte_i == dpd_pkg::ByteEscape) begin
          phase_d = dpd_pkg::PhEsc;
        end else if (byte_i == dpd_pkg::ByteOpen) begin
          // abort doubles as the start of a new packet
          has_result_o  = 1'b1;
          result_o.kind = dpd_pkg::EvAbort;
        end else if (byte_i == dpd_pkg::ByteClose) begin
          phase_d = dpd_pkg::PhChk1;
        end else begin
          has_result_o     = 1'b1;
          result_o.kind    = dpd_pkg::EvByte;
          result_o.payload = byte_i;
        end
      end
      dpd_pkg::PhEsc: begin
        phase_d          = dpd_pkg::PhData;
        has_result_o     = 1'b1;
        result_o.kind    = dpd_pkg::EvByte;
        result_o.payload = byte_i ^ dpd_pkg::EscapeMask;
      end
      dpd_pkg::PhChk1: begin
        chk1_d  = byte_i;
        phase_d = dpd_pkg::PhChk2;
      end
      dpd_pkg::PhChk2: begin
        phase_d         = dpd_pkg::PhIdle;
        has_result_o    = 1'b1;
        result_o.kind   = dpd_pkg::EvEnd;
        result_o.chk_hi = chk1_q;
        result_o.chk_lo = byte_i;
        result_o.ack    = ack_en_i;
      end
      default: begin
        phase_d = dpd_pkg::PhIdle;
        if (byte_i == dpd_pkg::ByteInterrupt) begin
          has_result_o  = 1'b1;
          result_o.kind = dpd_pkg::EvIntr;
        end else if (byte_i == dpd_pkg::ByteOpen) begin
          phase_d       = dpd_pkg::PhData;
          has_result_o  = 1'b1;
          result_o.kind = dpd_pkg::EvStart;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dpd_pkg::PhIdle;
      chk1_q  <= 8'h00;
    end else if (advance_i) begin
      phase_q <= phase_d;
      chk1_q  <= chk1_d;
    end
  end

endmodule

// ===== rtl/core/dpd_out_stage.sv =====
// Result register on the event channel.
module dpd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  dpd_pkg::result_t result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dpd_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  dpd_pkg::result_t result_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ===== rtl/core/debug_packet_deframer_top.sv =====
// Top level of the remote debug packet deframer.
//
// Input channel: one received byte per request on rx_byte_i, handshake
// in_valid_i / in_ready_o. Output channel: one framing event per request
// (event_kind_o, payload_byte_o, checksum_high_o, checksum_low_o,
// send_ack_o), handshake out_valid_o / out_ready_i. Bytes that close a
// request without an event (escape, '#', first checksum char, stray bytes
// outside a packet) produce nothing on the output.
// A taken byte waits in the input register, is decoded combinationally,
// and its event is then registered in the result register for output.
// Throughput: one byte per cycle unless an event byte finds the result
// register full; the combinational decode between the registers sets this.
// The ack-enable register is sampled at each packet end; it takes
// ack_enabled_i whenever ack_enabled_we_i is high and resets to 1.
// Reset clears both stage valids, returns framing to idle (outside any
// packet) and clears the held checksum character.
// Receiver stall: the result register holds; the input register still takes
// a byte, and further bytes that yield no event keep flowing. A byte that
// yields an event waits in the input register, so in_ready_o drops.
module debug_packet_deframer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       ack_enabled_we_i,
  input  logic       ack_enabled_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] checksum_high_o,
  output logic [7:0] checksum_low_o,
  output logic       send_ack_o
);

  logic             ack_en_q;
  logic             stage_valid;
  logic [7:0]       stage_byte;
  logic             advance;
  logic             has_result;
  logic             out_free;
  dpd_pkg::result_t dec_result;
  dpd_pkg::result_t out_result;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_en_q <= 1'b1;
    end else if (ack_enabled_we_i) begin
      ack_en_q <= ack_enabled_i;
    end
  end

  // the held byte moves on when it makes no event or the result slot frees up
  assign advance = stage_valid && (!has_result || out_free);

  dpd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  dpd_decoder u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .byte_i       (stage_byte),
    .ack_en_i     (ack_en_q),
    .has_result_o (has_result),
    .result_o     (dec_result)
  );

  dpd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_result),
    .result_i    (dec_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign event_kind_o    = out_result.kind;
  assign payload_byte_o  = out_result.payload;
  assign checksum_high_o = out_result.chk_hi;
  assign checksum_low_o  = out_result.chk_lo;
  assign send_ack_o      = out_result.ack;

endmodule
